// ===== hdl/crsv_pkg.sv =====
// Shared types and constants for the count record stream validator.
// Used by every module of the block; depends on nothing.
package crsv_pkg;

  localparam int FIELD_LIMIT = 64;
  localparam int RECORD_MAX  = 255;
  localparam int FC_MAX      = 127;
  localparam int FC_W        = 7;
  localparam int LEN_W       = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int DIGITS_W   = 5;
  localparam int LEAD_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_LEAD   = 2'd1;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 5'd10;
  localparam logic [LEAD_W-1:0]   LEAD_RESET   = 6'd49;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_COMMA,
    CLS_DOT,
    CLS_DIGIT,
    CLS_C,
    CLS_T,
    CLS_EQ,
    CLS_MINUS
  } cls_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_STAMP,
    PH_COUNT,
    PH_TICK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic             valid_res;
    logic [LEN_W-1:0] record_length;
  } out_t;

  typedef struct packed {
    cls_t cls;
    logic lead;
    logic last;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic                valid;
    logic                full;
    logic [QUEUE_CW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [DIGITS_W-1:0] stamp_digits;
  } cfg_t;

endpackage

// ===== hdl/crsv_front.sv =====
// Front end: configuration registers and byte classification.
// Depends on crsv_pkg; feeds crsv_queue and passes settings to crsv_back.
module crsv_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             q_full,
  input  crsv_pkg::in_t                    in_data,
  input  logic                             cfg_we,
  input  logic [crsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crsv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output crsv_pkg::q_push_t                q_push,
  output crsv_pkg::cfg_t                   cfg
);

  logic [crsv_pkg::DIGITS_W-1:0] digits_r;
  logic [crsv_pkg::LEAD_W-1:0]   lead_r;
  crsv_pkg::cls_t                cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= crsv_pkg::DIGITS_RESET;
      lead_r   <= crsv_pkg::LEAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crsv_pkg::CFG_STAMP_DIGITS: digits_r <= cfg_wdata[crsv_pkg::DIGITS_W-1:0];
        crsv_pkg::CFG_STAMP_LEAD:   lead_r   <= cfg_wdata[crsv_pkg::LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (in_data.ch)
      crsv_pkg::CH_LBRACE: cls = crsv_pkg::CLS_LBRACE;
      crsv_pkg::CH_RBRACE: cls = crsv_pkg::CLS_RBRACE;
      crsv_pkg::CH_COMMA:  cls = crsv_pkg::CLS_COMMA;
      crsv_pkg::CH_DOT:    cls = crsv_pkg::CLS_DOT;
      crsv_pkg::CH_C:      cls = crsv_pkg::CLS_C;
      crsv_pkg::CH_T:      cls = crsv_pkg::CLS_T;
      crsv_pkg::CH_EQ:     cls = crsv_pkg::CLS_EQ;
      crsv_pkg::CH_MINUS:  cls = crsv_pkg::CLS_MINUS;
      default: begin
        if (in_data.ch >= crsv_pkg::CH_ZERO && in_data.ch <= crsv_pkg::CH_NINE) begin
          cls = crsv_pkg::CLS_DIGIT;
        end else begin
          cls = crsv_pkg::CLS_OTHER;
        end
      end
    endcase
  end

  assign q_push.push      = in_valid && !q_full;
  assign q_push.item.cls  = cls;
  assign q_push.item.lead = (in_data.ch == {2'b00, lead_r});
  assign q_push.item.last = in_data.last;
  assign cfg.stamp_digits = digits_r;

endmodule

// ===== hdl/crsv_queue.sv =====
// Short queue of classified bytes between the front and back ends.
// Depends on crsv_pkg.
module crsv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  crsv_pkg::q_push_t   q_push,
  input  logic                pop,
  output crsv_pkg::q_item_t   q_head,
  output crsv_pkg::q_stat_t   q_stat
);

  crsv_pkg::q_item_t                 mem_r [crsv_pkg::QUEUE_DEPTH];
  logic [crsv_pkg::QUEUE_AW-1:0]     wr_ptr_r;
  logic [crsv_pkg::QUEUE_AW-1:0]     rd_ptr_r;
  logic [crsv_pkg::QUEUE_CW-1:0]     count_r;
  logic                              do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({q_push.push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign q_head       = mem_r[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == crsv_pkg::QUEUE_CW'(crsv_pkg::QUEUE_DEPTH));
  assign q_stat.count = count_r;

endmodule

// ===== hdl/crsv_back.sv =====
// Back end: record parser, counters and the output register.
// Depends on crsv_pkg; drains crsv_queue.
module crsv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  crsv_pkg::q_item_t   q_head,
  input  crsv_pkg::q_stat_t   q_stat,
  input  crsv_pkg::cfg_t      cfg,
  input  logic                out_stall,
  output logic                pop,
  output logic                out_valid,
  output crsv_pkg::out_t      out_data
);

  crsv_pkg::phase_t               phase_r, phase_nxt;
  logic [crsv_pkg::FC_W-1:0]      fc_r, fc_nxt;
  logic [crsv_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic                           bad_r, bad_nxt;
  logic                           open_r, open_nxt;
  logic                           out_valid_r;
  crsv_pkg::out_t                 out_r;
  logic                           emit;
  logic                           is_dot;
  logic                           ok;
  crsv_pkg::cls_t                 term, tag;

  assign pop    = q_stat.valid && (!out_valid_r || !out_stall);
  assign is_dot = (q_head.cls == crsv_pkg::CLS_DOT);

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    len_nxt   = len_r;
    bad_nxt   = bad_r;
    open_nxt  = open_r;
    ok        = 1'b0;
    term      = (phase_r == crsv_pkg::PH_COUNT) ? crsv_pkg::CLS_COMMA : crsv_pkg::CLS_RBRACE;
    tag       = (phase_r == crsv_pkg::PH_COUNT) ? crsv_pkg::CLS_C : crsv_pkg::CLS_T;
    if (!is_dot) begin
      open_nxt = 1'b1;
      if (len_r != crsv_pkg::LEN_W'(crsv_pkg::RECORD_MAX)) begin
        len_nxt = len_r + 1'b1;
      end
      if (!bad_r) begin
        case (phase_r)
          crsv_pkg::PH_START: begin
            if (q_head.cls == crsv_pkg::CLS_LBRACE) begin
              phase_nxt = crsv_pkg::PH_STAMP;
              fc_nxt    = '0;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          crsv_pkg::PH_STAMP: begin
            if (q_head.cls == crsv_pkg::CLS_COMMA) begin
              if (fc_r == '0 || fc_r != {2'b00, cfg.stamp_digits} ||
                  fc_r >= crsv_pkg::FC_W'(crsv_pkg::FIELD_LIMIT)) begin
                bad_nxt = 1'b1;
              end else begin
                phase_nxt = crsv_pkg::PH_COUNT;
                fc_nxt    = '0;
              end
            end else if (q_head.cls != crsv_pkg::CLS_DIGIT || (fc_r == '0 && !q_head.lead)) begin
              bad_nxt = 1'b1;
            end else if (fc_r != crsv_pkg::FC_W'(crsv_pkg::FC_MAX)) begin
              fc_nxt = fc_r + 1'b1;
            end
          end
          crsv_pkg::PH_COUNT, crsv_pkg::PH_TICK: begin
            if (q_head.cls == term) begin
              if (fc_r < crsv_pkg::FC_W'(3) ||
                  fc_r >= crsv_pkg::FC_W'(crsv_pkg::FIELD_LIMIT)) begin
                bad_nxt = 1'b1;
              end else begin
                phase_nxt = (phase_r == crsv_pkg::PH_COUNT) ? crsv_pkg::PH_TICK
                                                             : crsv_pkg::PH_DONE;
                fc_nxt    = '0;
              end
            end else begin
              if (fc_r == crsv_pkg::FC_W'(0)) begin
                ok = (q_head.cls == tag);
              end else if (fc_r == crsv_pkg::FC_W'(1)) begin
                ok = (q_head.cls == crsv_pkg::CLS_EQ);
              end else begin
                ok = (q_head.cls == crsv_pkg::CLS_DIGIT) ||
                     (fc_r == crsv_pkg::FC_W'(2) && q_head.cls == crsv_pkg::CLS_MINUS);
              end
              if (!ok) begin
                bad_nxt = 1'b1;
              end else if (fc_r != crsv_pkg::FC_W'(crsv_pkg::FC_MAX)) begin
                fc_nxt = fc_r + 1'b1;
              end
            end
          end
          default: bad_nxt = 1'b1;
        endcase
      end
    end
    emit = (is_dot || q_head.last) && open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crsv_pkg::PH_START;
      fc_r        <= '0;
      len_r       <= '0;
      bad_r       <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (emit) begin
          phase_r <= crsv_pkg::PH_START;
          fc_r    <= '0;
          len_r   <= '0;
          bad_r   <= 1'b0;
          open_r  <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          fc_r    <= fc_nxt;
          len_r   <= len_nxt;
          bad_r   <= bad_nxt;
          open_r  <= open_nxt;
        end
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_r.valid_res     <= !bad_nxt && (phase_nxt == crsv_pkg::PH_DONE);
      out_r.record_length <= len_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/count_record_stream_validator_top.sv =====
// Top level of the count record stream validator.
// Depends on crsv_pkg, crsv_front, crsv_queue and crsv_back.
//
// Bytes arrive on the in_ channel (in_valid, in_stall, in_data) and a
// transfer takes place at each clock edge where in_valid is high and
// in_stall is low. Each non-empty record, closed by a '.' or by the byte
// marked last, yields one verdict transfer on the out_ channel with the
// record length. Settings are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while no record is in flight;
// the block does not enforce this. One byte is taken every cycle while the
// queue is not full; the back-end parser handles one queued byte per cycle
// while the queue holds bytes and the output is not stalled. Each verdict
// is held in the output register, which drives out_valid.
// A four-entry queue separates the classifier from the parser, so the input
// can take up to four more bytes while a verdict waits in the output
// register. When the receiver stalls, the verdict holds, the parser stops
// and in_stall rises once the queue fills.
// Reset empties the queue, clears the parser state and the output valid flag
// and restores the default settings.
module count_record_stream_validator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  crsv_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output crsv_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [crsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crsv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  crsv_pkg::q_push_t  q_push;
  crsv_pkg::q_item_t  q_head;
  crsv_pkg::q_stat_t  q_stat;
  crsv_pkg::cfg_t     cfg;
  logic               pop;

  crsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .q_full    (q_stat.full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .cfg       (cfg)
  );

  crsv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  crsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .cfg       (cfg),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall = q_stat.full;

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.record_length != '0)
    else $error("verdict carries a zero record length");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> q_stat.count == crsv_pkg::QUEUE_CW'($past(q_stat.count)
      + $past(q_push.push) - ($past(pop) && $past(q_stat.valid))))
    else $error("queue occupancy out of step with transfers");

  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid) |-> $past(pop))
    else $error("verdict raised without a parsed byte");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.count != '0)
    else $error("parser consumed from an empty queue");

endmodule

// ===== dv/count_record_stream_validator_top_tb.sv =====
// Self-checking testbench for count_record_stream_validator_top.
// Drives record byte streams under several settings and checks every verdict
// against an internal predictor; depends on crsv_pkg and the RTL top level.
module count_record_stream_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int IDLE_PCT = 19;
  localparam int WATCHDOG = 5000;
  localparam logic [7:0] MARKS [10] = '{CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT, CH_C,
                                        CH_T, CH_EQ, CH_MINUS, 8'h00, 8'hFF};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  count_record_stream_validator_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state and its copy of the settings.
  logic [DIGITS_W-1:0] want_digits;
  logic [LEAD_W-1:0] want_lead;
  phase_t parse_phase;
  logic [FC_W-1:0] field_len;
  logic [LEN_W-1:0] rec_len;
  bit rec_bad;
  bit rec_open;

  in_t byte_q[$];
  out_t verdict_q[$];
  logic [7:0] rec_buf[$];

  out_t pred_res;
  out_t want_res;
  bit steady = 1'b0;
  int fail_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int setting_cnt = 0;
  int idle_cyc = 0;

  function automatic bit is_digit_ch(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_record();
    parse_phase = PH_START;
    field_len = '0;
    rec_len = '0;
    rec_bad = 1'b0;
    rec_open = 1'b0;
  endfunction

  function automatic void bump_field();
    if (field_len < FC_MAX) field_len++;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    logic [7:0] term;
    logic [7:0] tag;
    bit ok;
    rec_open = 1'b1;
    if (rec_len < RECORD_MAX) rec_len++;
    if (rec_bad) return;
    case (parse_phase)
      PH_START: begin
        if (c == CH_LBRACE) begin
          parse_phase = PH_STAMP;
          field_len = '0;
        end else begin
          rec_bad = 1'b1;
        end
      end
      PH_STAMP: begin
        if (c == CH_COMMA) begin
          if (field_len == 0 || field_len != {2'b00, want_digits} ||
              field_len >= FIELD_LIMIT) begin
            rec_bad = 1'b1;
          end else begin
            parse_phase = PH_COUNT;
            field_len = '0;
          end
        end else if (!is_digit_ch(c) || (field_len == 0 && c != {2'b00, want_lead})) begin
          rec_bad = 1'b1;
        end else begin
          bump_field();
        end
      end
      PH_COUNT, PH_TICK: begin
        term = (parse_phase == PH_COUNT) ? CH_COMMA : CH_RBRACE;
        tag = (parse_phase == PH_COUNT) ? CH_C : CH_T;
        if (c == term) begin
          if (field_len < 3 || field_len >= FIELD_LIMIT) begin
            rec_bad = 1'b1;
          end else begin
            parse_phase = (parse_phase == PH_COUNT) ? PH_TICK : PH_DONE;
            field_len = '0;
          end
        end else begin
          if (field_len == 0) ok = (c == tag);
          else if (field_len == 1) ok = (c == CH_EQ);
          else ok = is_digit_ch(c) || (field_len == 2 && c == CH_MINUS);
          if (!ok) rec_bad = 1'b1;
          else bump_field();
        end
      end
      default: rec_bad = 1'b1;
    endcase
  endfunction

  function automatic bit verdict_predict(in_t d, output out_t r);
    r = '0;
    if (d.ch != CH_DOT) take_byte(d.ch);
    if ((d.ch == CH_DOT || d.last) && rec_open) begin
      r.valid_res = !rec_bad && parse_phase == PH_DONE;
      r.record_length = rec_len;
      clear_record();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Stimulus construction.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return MARKS[$urandom_range(0, 9)];
      1: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] c, bit l);
    byte_q.push_back(in_t'{ch: c, last: l});
  endfunction

  function automatic void push_text(string s, bit last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(8'(s[i]), last_on_end && i == s.len() - 1);
    end
  endfunction

  function automatic void push_digits(int n, logic [7:0] lead);
    for (int i = 0; i < n; i++) begin
      rec_buf.push_back(i == 0 ? lead : CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_field(logic [7:0] tag);
    int r;
    int n;
    rec_buf.push_back(tag);
    rec_buf.push_back(CH_EQ);
    if ($urandom_range(0, 3) == 0) rec_buf.push_back(CH_MINUS);
    r = $urandom_range(0, 19);
    if (r == 0) n = 0;
    else if (r == 1) n = $urandom_range(59, 62);
    else n = $urandom_range(1, 5);
    push_digits(n, CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void build_good();
    int n;
    int r;
    logic [7:0] lead;
    n = want_digits;
    r = $urandom_range(0, 9);
    if (r == 0) n = n + 1;
    else if (r == 1 && n > 0) n = n - 1;
    if (is_digit_ch({2'b00, want_lead}) && $urandom_range(0, 9) != 0) lead = {2'b00, want_lead};
    else lead = CH_ZERO + 8'($urandom_range(0, 9));
    rec_buf.push_back(CH_LBRACE);
    push_digits(n, lead);
    rec_buf.push_back(CH_COMMA);
    add_field(CH_C);
    rec_buf.push_back(CH_COMMA);
    add_field(CH_T);
    rec_buf.push_back(CH_RBRACE);
  endfunction

  function automatic void mangle();
    int pos;
    if (rec_buf.size() == 0) return;
    pos = $urandom_range(0, rec_buf.size() - 1);
    case ($urandom_range(0, 2))
      0: rec_buf[pos] = noise_byte();
      1: rec_buf.insert(pos, noise_byte());
      default: rec_buf.delete(pos);
    endcase
  endfunction

  function automatic void build_record();
    int mode;
    logic [7:0] b;
    mode = $urandom_range(0, 99);
    rec_buf.delete();
    if (mode < 85) begin
      build_good();
      if (mode >= 60 && mode < 75) begin
        mangle();
      end else if (mode >= 75) begin
        repeat ($urandom_range(1, 3)) rec_buf.push_back(noise_byte());
      end
    end else if (mode < 98) begin
      repeat ($urandom_range(0, 12)) rec_buf.push_back(noise_byte());
    end else if (mode == 98) begin
      build_good();
      repeat ($urandom_range(235, 300)) begin
        b = noise_byte();
        rec_buf.push_back(b == CH_DOT ? CH_RBRACE : b);
      end
    end else begin
      rec_buf.push_back(CH_LBRACE);
      push_digits(130, {2'b00, want_lead});
      rec_buf.push_back(CH_COMMA);
      add_field(CH_C);
      rec_buf.push_back(CH_COMMA);
      add_field(CH_T);
      rec_buf.push_back(CH_RBRACE);
    end
  endfunction

  function automatic void emit_record();
    int t;
    int sz;
    t = $urandom_range(0, 9);
    sz = rec_buf.size();
    for (int i = 0; i < sz; i++) begin
      push_byte(rec_buf[i], t == 7 && i == sz - 1);
    end
    if (t != 7 || sz == 0) push_byte(CH_DOT, t == 8 || (t == 7 && sz == 0));
    if (t == 9) push_byte(CH_DOT, 1'b0);
  endfunction

  function automatic void fill_bytes(int n);
    int stop;
    stop = byte_q.size() + n;
    while (byte_q.size() < stop) begin
      build_record();
      emit_record();
    end
    push_byte(CH_DOT, 1'($urandom_range(0, 1)));
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_STAMP_DIGITS: want_digits = val[DIGITS_W-1:0];
      CFG_STAMP_LEAD: want_lead = val[LEAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_setting(logic [CFG_DATA_W-1:0] digits, logic [CFG_DATA_W-1:0] lead,
                             bit spare, bit calm, int n);
    cfg_write(CFG_STAMP_DIGITS, digits);
    cfg_write(CFG_STAMP_LEAD, lead);
    if (spare) begin
      cfg_write(CFG_SPARE_A, 6'($urandom_range(0, 63)));
      cfg_write(CFG_SPARE_B, 6'($urandom_range(0, 63)));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    steady = calm;
    setting_cnt++;
    fill_bytes(n);
    drain();
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sent_cnt++;
        if (verdict_predict(in_data, pred_res)) verdict_q.push_back(pred_res);
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor and watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      idle_cyc = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict valid_res=%0d record_length=%0d", $time,
                   out_data.valid_res, out_data.record_length);
          fail_cnt++;
        end else begin
          want_res = verdict_q.pop_front();
          checked_cnt++;
          if (out_data.valid_res !== want_res.valid_res) begin
            $display("%0t: valid_res mismatch, expected %0d, actual %0d", $time,
                     want_res.valid_res, out_data.valid_res);
            fail_cnt++;
          end
          if (out_data.record_length !== want_res.record_length) begin
            $display("%0t: record_length mismatch, expected %0d, actual %0d", $time,
                     want_res.record_length, out_data.record_length);
            fail_cnt++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
        $display("count_record_stream_validator_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    want_digits = DIGITS_RESET;
    want_lead = LEAD_RESET;
    clear_record();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(CH_DOT, 1'b0);
    push_text("{1234567890,c=5,t=-3}", 1'b1);
    push_byte(CH_DOT, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_DOT, 1'b0);
    setting_cnt++;
    fill_bytes(130);
    drain();

    run_setting(6'd20, 6'd57, 1'b0, 1'b0, 130);
    run_setting(6'd1, 6'd48, 1'b0, 1'b0, 130);
    run_setting(6'd0, 6'd53, 1'b0, 1'b0, 130);
    run_setting(6'd63, 6'd63, 1'b1, 1'b0, 130);
    run_setting(6'd7, 6'd0, 1'b1, 1'b0, 130);
    run_setting(6'd47, 6'd47, 1'b0, 1'b0, 130);
    run_setting(6'd10, 6'd49, 1'b0, 1'b1, 300);
    repeat (4) begin
      run_setting(6'($urandom_range(1, 20)), 6'($urandom_range(48, 57)),
                  1'($urandom_range(0, 1)), 1'b0, 130);
    end

    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, verdict_q.size());
      fail_cnt += verdict_q.size();
    end
    $display("Sent %0d bytes under %0d settings and checked %0d verdicts.", sent_cnt,
             setting_cnt, checked_cnt);
    if (fail_cnt == 0) begin
      $display("count_record_stream_validator_top verification clean");
    end else begin
      $display("count_record_stream_validator_top verification failed");
    end
    $finish;
  end

endmodule
